[src/ctbs_pkg.sv]
// shared types and constants for the can transmit buffer scheduler
`timescale 1ns / 1ps
package ctbs_pkg;

    localparam int MODE_W   = 2;
    localparam int IDX_W    = 5;
    localparam int IDENT_W  = 11;
    localparam int DLC_W    = 4;
    localparam int CFG_W    = 6;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int SDEL_W   = 2;
    localparam int WCNT_W   = IDX_W + 1;

    localparam int NUM_SLOTS = 1 << IDX_W;
    localparam int ENTRY_W   = IDENT_W + 1 + DLC_W;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(32);

    localparam logic [MODE_W-1:0] MODE_SETUP    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SEND     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DONE     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SYNC_CLR = 2'd3;

    localparam logic [KIND_W-1:0] KIND_SEND_STATUS  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LAUNCHED     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SYNC_CLEARED = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;

    localparam logic [SDEL_W-1:0] SD_NONE    = 2'd0;
    localparam logic [SDEL_W-1:0] SD_ABORTED = 2'd1;
    localparam logic [SDEL_W-1:0] SD_DROPPED = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [IDX_W-1:0]   idx;
        logic               in_range;
        logic [IDENT_W-1:0] ident;
        logic               rtr;
        logic [DLC_W-1:0]   dlc;
        logic               sync;
        logic               hw_free;
        logic               tx_in_progress;
    } t_cmd;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [STATUS_W-1:0] status;
        logic                tx_now;
        logic [IDX_W-1:0]    index;
        logic [IDENT_W-1:0]  ident;
        logic                rtr;
        logic [DLC_W-1:0]    dlc;
        logic                ovf;
        logic                abort;
        logic [SDEL_W-1:0]   sync_del;
    } t_res;

endpackage

[src/ctbs_req_if.sv]
// request channel interface
`timescale 1ns / 1ps
interface ctbs_req_if import ctbs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [IDX_W-1:0]   entry_index;
    logic [IDENT_W-1:0] in_ident;
    logic               in_rtr;
    logic [DLC_W-1:0]   in_dlc;
    logic               in_sync;
    logic               hw_free;
    logic               tx_in_progress;

    modport source (
        output valid, mode, entry_index, in_ident, in_rtr, in_dlc, in_sync, hw_free,
               tx_in_progress,
        input  ready
    );
    modport sink (
        input  valid, mode, entry_index, in_ident, in_rtr, in_dlc, in_sync, hw_free,
               tx_in_progress,
        output ready
    );
endinterface

[src/ctbs_res_if.sv]
// result channel interface
`timescale 1ns / 1ps
interface ctbs_res_if import ctbs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   result_kind;
    logic [STATUS_W-1:0] status;
    logic                transmit_now;
    logic [IDX_W-1:0]    out_index;
    logic [IDENT_W-1:0]  out_ident;
    logic                out_rtr;
    logic [DLC_W-1:0]    out_dlc;
    logic                overflow_report;
    logic                abort_hardware;
    logic [SDEL_W-1:0]   sync_deleted;

    modport source (
        output valid, result_kind, status, transmit_now, out_index, out_ident, out_rtr,
               out_dlc, overflow_report, abort_hardware, sync_deleted,
        input  ready
    );
    modport sink (
        input  valid, result_kind, status, transmit_now, out_index, out_ident, out_rtr,
               out_dlc, overflow_report, abort_hardware, sync_deleted,
        output ready
    );
endinterface

[src/ctbs_ram.sv]
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
module ctbs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[src/ctbs_front.sv]
// front end: accepts requests, range checks and queues commands
`timescale 1ns / 1ps
module ctbs_front import ctbs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CFG_W-1:0] i_size,
    ctbs_req_if.sink         i_req,
    input  logic             i_full,
    output logic             o_push,
    output t_cmd             o_cmd
);
    logic in_range;

    assign in_range = ({1'b0, i_req.entry_index} < i_size);
    assign i_req.ready = !i_full;

    always_comb begin
        o_cmd.mode           = i_req.mode;
        o_cmd.idx            = i_req.entry_index;
        o_cmd.in_range       = in_range;
        o_cmd.ident          = i_req.in_ident;
        o_cmd.rtr            = i_req.in_rtr;
        o_cmd.dlc            = i_req.in_dlc;
        o_cmd.sync           = i_req.in_sync;
        o_cmd.hw_free        = i_req.hw_free;
        o_cmd.tx_in_progress = i_req.tx_in_progress;
    end

    // out of range set up is dropped here, it has no effect and no result
    assign o_push = i_req.valid && !i_full && !(i_req.mode == MODE_SETUP && !in_range);

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> i_req.ready)
        else $error("push while queue full");
endmodule

[src/ctbs_fifo.sv]
// short command queue between front and back
`timescale 1ns / 1ps
module ctbs_fifo import ctbs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_full,
    output logic o_empty
);
    t_cmd                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_PTR_W:0]   r_cnt, n_cnt;
    logic                   do_push, do_pop;

    assign o_full  = (r_cnt == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (do_push) begin
            n_wr_ptr = r_wr_ptr + QUEUE_PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = r_rd_ptr + QUEUE_PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + (QUEUE_PTR_W + 1)'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - (QUEUE_PTR_W + 1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end
endmodule

[src/ctbs_back.sv]
// back end: executes commands against the transmit table and drives results
`timescale 1ns / 1ps
module ctbs_back import ctbs_pkg::*; #(
    parameter int DEPTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CFG_W-1:0] i_size,
    input  logic             i_empty,
    input  t_cmd             i_head,
    output logic             o_pop,
    ctbs_res_if.source       o_res
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NG = (DEPTH + 7) / 8;
    localparam int GW = 4;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_RESP = 2'd2;

    logic [1:0]        r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [DEPTH-1:0]  r_sel, n_sel;
    logic              r_hit, n_hit;
    logic [AW-1:0]     r_hit_idx, n_hit_idx;
    logic [GW-1:0]     r_grp [NG];
    logic [GW-1:0]     n_grp [NG];
    logic [DEPTH-1:0]  r_wait, n_wait;
    logic [DEPTH-1:0]  r_sync, n_sync;
    logic [WCNT_W-1:0] r_wait_cnt, n_wait_cnt;
    logic              r_inhibit, n_inhibit;
    logic              r_first, n_first;
    t_res              r_res, n_res;
    t_res              r_out, n_out;
    logic              r_out_valid, n_out_valid;

    logic [DEPTH-1:0]  rng;
    logic [DEPTH-1:0]  sync_term;
    logic [DEPTH-1:0]  sel;
    logic [DEPTH-1:0]  low;
    logic [AW-1:0]     hit_idx;
    logic [NG*8-1:0]   sel_pad;
    logic [GW-1:0]     grp [NG];
    logic [WCNT_W-1:0] pc;
    logic [AW-1:0]     cidx;
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

    ctbs_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (cidx),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign cidx      = r_cmd.idx[AW-1:0];
    assign ram_wdata = {r_cmd.ident, r_cmd.rtr, r_cmd.dlc};

    // scan of the waiting flags for the head command
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            rng[i] = (CFG_W'(i) < i_size);
        end
        sync_term = (i_head.mode == MODE_SYNC_CLR) ? r_sync : {DEPTH{1'b1}};
        sel       = r_wait & rng & sync_term;
        low       = sel & (~sel + DEPTH'(1));
        hit_idx   = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (low[i]) begin
                hit_idx = hit_idx | AW'(i);
            end
        end
        sel_pad = (NG * 8)'(sel);
        for (int g = 0; g < NG; g++) begin
            grp[g] = '0;
            for (int b = 0; b < 8; b++) begin
                grp[g] = grp[g] + GW'(sel_pad[g * 8 + b]);
            end
        end
    end

    always_comb begin
        pc = '0;
        for (int g = 0; g < NG; g++) begin
            pc = pc + WCNT_W'(r_grp[g]);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_sel       = r_sel;
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_grp       = r_grp;
        n_wait      = r_wait;
        n_sync      = r_sync;
        n_wait_cnt  = r_wait_cnt;
        n_inhibit   = r_inhibit;
        n_first     = r_first;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        o_pop       = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = cidx;

        if (o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop     = 1'b1;
                    n_cmd     = i_head;
                    n_sel     = sel;
                    n_hit     = |sel;
                    n_hit_idx = hit_idx;
                    n_grp     = grp;
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res   = '0;
                n_state = S_IDLE;
                case (r_cmd.mode)
                    MODE_SETUP: begin
                        if (r_cmd.in_range) begin
                            ram_we       = 1'b1;
                            n_sync[cidx] = r_cmd.sync;
                            if (r_wait[cidx] && r_wait_cnt != '0) begin
                                n_wait_cnt = r_wait_cnt - WCNT_W'(1);
                            end
                            n_wait[cidx] = 1'b0;
                        end
                    end
                    MODE_SEND: begin
                        n_state    = S_RESP;
                        n_res.kind = KIND_SEND_STATUS;
                        if (!r_cmd.in_range) begin
                            n_res.status = ST_RANGE;
                        end else begin
                            if (r_wait[cidx]) begin
                                n_res.status = ST_OVERFLOW;
                                n_res.ovf    = !r_first;
                            end
                            if (r_cmd.hw_free && r_wait_cnt == '0) begin
                                n_inhibit    = r_sync[cidx];
                                n_res.tx_now = 1'b1;
                                n_res.index  = r_cmd.idx;
                                ram_re       = 1'b1;
                            end else if (!r_wait[cidx]) begin
                                n_wait[cidx] = 1'b1;
                                n_wait_cnt   = r_wait_cnt + WCNT_W'(1);
                            end
                        end
                    end
                    MODE_DONE: begin
                        n_first   = 1'b0;
                        n_inhibit = 1'b0;
                        if (r_wait_cnt != '0) begin
                            if (r_hit) begin
                                n_wait[r_hit_idx] = 1'b0;
                                n_wait_cnt        = r_wait_cnt - WCNT_W'(1);
                                n_inhibit         = r_sync[r_hit_idx];
                                n_res.kind        = KIND_LAUNCHED;
                                n_res.tx_now      = 1'b1;
                                n_res.index       = IDX_W'(r_hit_idx);
                                ram_re            = 1'b1;
                                ram_raddr         = r_hit_idx;
                                n_state           = S_RESP;
                            end else begin
                                // waiting flags only beyond the active size
                                n_wait_cnt = '0;
                            end
                        end
                    end
                    default: begin
                        n_state    = S_RESP;
                        n_res.kind = KIND_SYNC_CLEARED;
                        if (r_cmd.tx_in_progress && r_inhibit) begin
                            n_res.abort    = 1'b1;
                            n_res.sync_del = SD_ABORTED;
                            n_inhibit      = 1'b0;
                        end
                        if (r_wait_cnt != '0) begin
                            n_wait = r_wait & ~r_sel;
                            if (r_hit) begin
                                n_res.sync_del = SD_DROPPED;
                            end
                            n_wait_cnt = (r_wait_cnt >= pc) ? r_wait_cnt - pc : '0;
                        end
                    end
                endcase
            end
            S_RESP: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out = r_res;
                    if (r_res.tx_now) begin
                        n_out.ident = ram_rdata[ENTRY_W-1 -: IDENT_W];
                        n_out.rtr   = ram_rdata[DLC_W];
                        n_out.dlc   = ram_rdata[DLC_W-1:0];
                    end
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wait      <= '0;
            r_wait_cnt  <= '0;
            r_inhibit   <= 1'b0;
            r_first     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wait      <= n_wait;
            r_wait_cnt  <= n_wait_cnt;
            r_inhibit   <= n_inhibit;
            r_first     <= n_first;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_sel     <= n_sel;
        r_hit     <= n_hit;
        r_hit_idx <= n_hit_idx;
        r_grp     <= n_grp;
        r_sync    <= n_sync;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.result_kind     = r_out.kind;
    assign o_res.status          = r_out.status;
    assign o_res.transmit_now    = r_out.tx_now;
    assign o_res.out_index       = r_out.index;
    assign o_res.out_ident       = r_out.ident;
    assign o_res.out_rtr         = r_out.rtr;
    assign o_res.out_dlc         = r_out.dlc;
    assign o_res.overflow_report = r_out.ovf;
    assign o_res.abort_hardware  = r_out.abort;
    assign o_res.sync_deleted    = r_out.sync_del;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wait_cnt <= WCNT_W'(DEPTH))
        else $error("waiting count above table depth");

    a_launch_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.transmit_now |->
            o_res.result_kind != KIND_SYNC_CLEARED && o_res.status != ST_RANGE)
        else $error("launch on a result that cannot carry one");

    a_ovf_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.overflow_report |-> o_res.status == ST_OVERFLOW)
        else $error("overflow report without overflow status");

    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EXEC && r_cmd.mode == MODE_DONE && r_wait_cnt != '0 && r_hit
            |=> !r_wait[$past(r_hit_idx)])
        else $error("launched entry still waiting");
endmodule

[src/can_transmit_buffer_scheduler.sv]
// top level of the can transmit buffer scheduler
// a request with a result passes the command queue and the back states idle, exec
// and resp before o_res; resp holds until o_res is free. one without a result ends
// after exec; a 2 deep command queue lets requests arrive while results wait
// reset: waiting flags, waiting count and inhibit cleared, first message flag set,
// entries_in_use set to 32; table contents stay undefined, there is no clearing pass
`timescale 1ns / 1ps
module can_transmit_buffer_scheduler import ctbs_pkg::*; #(
    parameter int MAX_ENTRIES = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    ctbs_req_if.sink         i_req,
    ctbs_res_if.source       o_res
);
    localparam int DEPTH = (MAX_ENTRIES < NUM_SLOTS) ? MAX_ENTRIES : NUM_SLOTS;

    logic [CFG_W-1:0] r_entries_in_use;
    logic [CFG_W-1:0] size;
    logic             push, pop, full, empty;
    t_cmd             cmd, head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries_in_use <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_entries_in_use <= i_cfg_wdata;
        end
    end

    assign size = (r_entries_in_use > CFG_W'(DEPTH)) ? CFG_W'(DEPTH) : r_entries_in_use;

    ctbs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_size  (size),
        .i_req   (i_req),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (cmd)
    );

    ctbs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (full),
        .o_empty (empty)
    );

    ctbs_back #(.DEPTH(DEPTH)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_size  (size),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_res   (o_res)
    );
endmodule
